// ----- design/acbs_pkg.sv -----
package acbs_pkg;

  localparam int unsigned AlphabetSize = 26;

  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharLowerZ = 8'h7a;  // 'z'
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperZ = 8'h5a;  // 'Z'

  localparam logic [4:0] Alpha = 5'(AlphabetSize);

  // register indexes of the config port
  localparam logic [1:0] CfgKeyMult  = 2'd0;
  localparam logic [1:0] CfgKeyAdd   = 2'd1;
  localparam logic [1:0] CfgDirection = 2'd2;

  // reciprocal of the alphabet size, scaled by 2^RecipShift, rounded down
  localparam int unsigned RecipShift = 13;
  localparam logic [8:0]  RecipMult  = 9'((1 << RecipShift) / AlphabetSize);

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       key_error;
  } out_word_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] raw_char;
    logic       last;
    logic       key_error;
    logic       xform;     // letter that gets transformed
    logic       upper;
    logic [4:0] operand;
    logic [4:0] mult;
    logic [4:0] addend;
  } task_t;

  // reduce a 5-bit key into 0..25
  function automatic logic [4:0] mod_key(input logic [4:0] k);
    mod_key = (k >= Alpha) ? (k - Alpha) : k;
  endfunction

  // inverse modulo 26, zero when there is none
  function automatic logic [4:0] inv_key(input logic [4:0] a);
    logic [4:0] r;
    unique case (a)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    inv_key = r;
  endfunction

endpackage

// ----- design/acbs_front.sv -----
module acbs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [4:0]       cfg_data_i,
  input  acbs_pkg::in_word_t in_word_i,
  output acbs_pkg::task_t  task_o
);

  logic [4:0] key_mult_q, key_mult_d;
  logic [4:0] key_add_q, key_add_d;
  logic       dir_q, dir_d;

  always_comb begin
    key_mult_d = key_mult_q;
    key_add_d  = key_add_q;
    dir_d      = dir_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acbs_pkg::CfgKeyMult:   key_mult_d = cfg_data_i;
        acbs_pkg::CfgKeyAdd:    key_add_d  = cfg_data_i;
        acbs_pkg::CfgDirection: dir_d      = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mult_q <= 5'd1;
      key_add_q  <= 5'd0;
      dir_q      <= 1'b0;
    end else begin
      key_mult_q <= key_mult_d;
      key_add_q  <= key_add_d;
      dir_q      <= dir_d;
    end
  end

  logic       is_lower, is_upper, err;
  logic [4:0] key_a, key_b, key_inv, val;
  logic [7:0] ch, offs;

  always_comb begin
    ch       = in_word_i.in_char;
    is_lower = (ch >= acbs_pkg::CharLowerA) && (ch <= acbs_pkg::CharLowerZ);
    is_upper = (ch >= acbs_pkg::CharUpperA) && (ch <= acbs_pkg::CharUpperZ);
    offs     = is_upper ? (ch - acbs_pkg::CharUpperA) : (ch - acbs_pkg::CharLowerA);
    val      = offs[4:0];
    key_a    = acbs_pkg::mod_key(key_mult_q);
    key_b    = acbs_pkg::mod_key(key_add_q);
    key_inv  = acbs_pkg::inv_key(key_a);
    err      = dir_q && (key_inv == 5'd0);

    task_o.raw_char  = ch;
    task_o.last      = in_word_i.in_last;
    task_o.key_error = err;
    task_o.xform     = (is_lower || is_upper) && !err;
    task_o.upper     = is_upper;
    if (dir_q) begin
      // decrypt: inv * ((v - b) mod 26)
      task_o.operand = (val >= key_b) ? (val - key_b) : (val + acbs_pkg::Alpha - key_b);
      task_o.mult    = key_inv;
      task_o.addend  = 5'd0;
    end else begin
      task_o.operand = val;
      task_o.mult    = key_a;
      task_o.addend  = key_b;
    end
  end

endmodule

// ----- design/acbs_fifo.sv -----
module acbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  acbs_pkg::task_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output acbs_pkg::task_t rdata_o
);

  acbs_pkg::task_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       wr_fire, rd_fire;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign wr_fire = wr_i && !full_o;
  assign rd_fire = rd_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_fire && !rd_fire) cnt_d = cnt_q + 2'd1;
    else if (!wr_fire && rd_fire) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_fire) wr_ptr_q <= !wr_ptr_q;
      if (rd_fire) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ----- design/acbs_back.sv -----
module acbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               task_valid_i,
  input  acbs_pkg::task_t    task_i,
  output logic               task_take_o,
  input  logic               pop,
  output logic               empty,
  output acbs_pkg::out_word_t out_word_o
);

  // stage 1: product plus addend
  logic            s1_valid_q, s1_valid_d;
  logic [9:0]      s1_sum_q;
  acbs_pkg::task_t s1_task_q;

  // output queue
  acbs_pkg::out_word_t out_mem_q [2];
  logic [1:0] out_cnt_q, out_cnt_d;
  logic       out_wr_q, out_rd_q;
  logic       pop_fire, out_space, s1_adv, s1_load;

  assign empty      = (out_cnt_q == 2'd0);
  assign out_word_o = out_mem_q[out_rd_q];
  assign pop_fire   = pop && !empty;
  assign out_space  = (out_cnt_q != 2'd2) || pop_fire;
  assign s1_adv     = s1_valid_q && out_space;
  assign s1_load    = task_valid_i && (!s1_valid_q || out_space);
  assign task_take_o = s1_load;
  assign s1_valid_d = s1_load || (s1_valid_q && !out_space);

  logic [9:0] sum;
  assign sum = 10'(task_i.mult) * 10'(task_i.operand) + 10'(task_i.addend);

  // stage 2: reduce mod 26 by reciprocal estimate and one correction
  logic [18:0] q_prod;
  logic [5:0]  q_est;
  logic [9:0]  rem_w;
  logic [5:0]  rem;
  logic [4:0]  letter;
  acbs_pkg::out_word_t res;

  always_comb begin
    q_prod = 19'(s1_sum_q) * 19'(acbs_pkg::RecipMult);
    q_est  = q_prod[acbs_pkg::RecipShift +: 6];
    rem_w  = s1_sum_q - 10'(q_est) * 10'(acbs_pkg::AlphabetSize);
    rem    = rem_w[5:0];
    letter = (rem >= 6'(acbs_pkg::AlphabetSize)) ?
             5'(rem - 6'(acbs_pkg::AlphabetSize)) : rem[4:0];
    res.out_last  = s1_task_q.last;
    res.key_error = s1_task_q.key_error;
    if (s1_task_q.xform) begin
      res.out_char = (s1_task_q.upper ? acbs_pkg::CharUpperA : acbs_pkg::CharLowerA)
                     + 8'(letter);
    end else begin
      res.out_char = s1_task_q.raw_char;
    end
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (s1_adv && !pop_fire) out_cnt_d = out_cnt_q + 2'd1;
    else if (!s1_adv && pop_fire) out_cnt_d = out_cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_cnt_q  <= 2'd0;
      out_wr_q   <= 1'b0;
      out_rd_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_cnt_q  <= out_cnt_d;
      if (s1_adv) out_wr_q <= !out_wr_q;
      if (pop_fire) out_rd_q <= !out_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_sum_q  <= sum;
      s1_task_q <= task_i;
    end
    if (s1_adv) out_mem_q[out_wr_q] <= res;
  end

endmodule

// ----- design/affine_cipher_byte_stream_core.sv -----
// affine mod-26 cipher on a byte stream, one result word per input word
// a pushed word passes the task queue, stage 1 and the output queue before empty goes low
// throughput: one word per cycle while the output is popped, set by the combinational
//   front classifier, the 5x5 multiply stage and the back end's mod-26 reduction stage
// reset: async active low; keys return to mult 1, add 0, encrypt; both queues empty
module affine_cipher_byte_stream_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [4:0]          cfg_data_i,
  // input queue side
  input  logic                push,
  output logic                full,
  input  acbs_pkg::in_word_t  in_word_i,
  // result queue side
  input  logic                pop,
  output logic                empty,
  output acbs_pkg::out_word_t out_word_o
);

  // classified word from the front end
  acbs_pkg::task_t front_task;

  // task queue to back end
  acbs_pkg::task_t q_task;
  logic            q_valid;
  logic            q_take;

  // front end: key registers, letter classification, operand selection
  // decrypt is folded into the same multiply-add form as encrypt
  acbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .task_o     (front_task)
  );

  // two-entry queue decouples front and back stalls
  acbs_fifo u_task_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_task),
    .full_o  (full),
    .rd_i    (q_take),
    .valid_o (q_valid),
    .rdata_o (q_task)
  );

  // back end: multiply-add, mod 26 reduction, output queue
  acbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_valid_i (q_valid),
    .task_i       (q_task),
    .task_take_o  (q_take),
    .pop          (pop),
    .empty        (empty),
    .out_word_o   (out_word_o)
  );

endmodule

// ----- sim/tb_affine_cipher_byte_stream_core.sv -----
module tb_affine_cipher_byte_stream_core;
  timeunit 1ns;
  timeprecision 1ps;

  // register index that the block has no register for
  localparam logic [1:0] CfgNone = 2'd3;
  // wait after draining, long enough for any stray word to reach the output
  localparam int unsigned DrainCycles = 8;
  // run limit, far beyond the slowest correct run
  localparam int unsigned LimitNs = 2_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [4:0] cfg_data_i;
  logic      push;
  logic      full;
  acbs_pkg::in_word_t  in_word_i;
  logic      pop;
  logic      empty;
  acbs_pkg::out_word_t out_word_o;

  affine_cipher_byte_stream_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

  // shadow copy of the key registers
  logic [4:0] key_mult_q;
  logic [4:0] key_add_q;
  logic       decrypt_q;

  // cipher words still owed by the block, oldest first
  acbs_pkg::out_word_t cipher_q[$];
  int unsigned err_cnt;

  // idle controls shared with the sender and the receiver
  bit send_idle;
  bit recv_idle;
  int unsigned hold_cycles;

  // free-running clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(LimitNs * 1ns);
    $display("DONE: errors detected");
    $finish;
  end

  // affine map on one byte under the current keys
  function automatic acbs_pkg::out_word_t cipher_byte(input acbs_pkg::in_word_t w);
    acbs_pkg::out_word_t r;
    int unsigned a;
    int unsigned b;
    int unsigned inv;
    int unsigned v;
    logic [7:0]  base;
    bit          letter;
    a = key_mult_q % acbs_pkg::AlphabetSize;
    b = key_add_q % acbs_pkg::AlphabetSize;
    // search for the inverse of a, zero when a shares a factor with 26
    inv = 0;
    for (int unsigned k = 1; k < acbs_pkg::AlphabetSize; k++) begin
      if ((a * k) % acbs_pkg::AlphabetSize == 1) inv = k;
    end
    letter = 1'b0;
    base = '0;
    if (w.in_char >= acbs_pkg::CharLowerA && w.in_char <= acbs_pkg::CharLowerZ) begin
      letter = 1'b1;
      base = acbs_pkg::CharLowerA;
    end else if (w.in_char >= acbs_pkg::CharUpperA && w.in_char <= acbs_pkg::CharUpperZ) begin
      letter = 1'b1;
      base = acbs_pkg::CharUpperA;
    end
    r.out_char  = w.in_char;
    r.out_last  = w.in_last;
    r.key_error = decrypt_q && (inv == 0);
    if (letter) begin
      v = w.in_char - base;
      if (!decrypt_q) begin
        r.out_char = base + 8'((a * v + b) % acbs_pkg::AlphabetSize);
      end else if (!r.key_error) begin
        // decrypt: subtract the offset first, then undo the multiply
        v = (v + acbs_pkg::AlphabetSize - b) % acbs_pkg::AlphabetSize;
        r.out_char = base + 8'((inv * v) % acbs_pkg::AlphabetSize);
      end
    end
    return r;
  endfunction

  // byte generator biased toward letters so the cipher path sees most traffic
  function automatic logic [7:0] pick_char();
    case ($urandom_range(3))
      0:       return acbs_pkg::CharLowerA + 8'($urandom_range(25));
      1:       return acbs_pkg::CharUpperA + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one word until the block takes it, called and returning at a falling edge
  task automatic send_word(input logic [7:0] ch, input logic last);
    acbs_pkg::in_word_t w;
    w.in_char = ch;
    w.in_last = last;
    while (send_idle && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    cipher_q.push_back(cipher_byte(w));
    @(negedge clk_i);
  endtask

  // one string of random bytes, last flag on its final byte
  task automatic send_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(pick_char(), i == len - 1);
    end
  endtask

  // stop offering and wait until every owed word has come out
  task automatic wait_drained();
    push <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk_i);
  endtask

  // register write, only while the block is drained
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      acbs_pkg::CfgKeyMult:   key_mult_q = data;
      acbs_pkg::CfgKeyAdd:    key_add_q  = data;
      acbs_pkg::CfgDirection: decrypt_q  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_keys(input logic [4:0] mult, input logic [4:0] add,
                          input logic dec);
    wait_drained();
    write_reg(acbs_pkg::CfgKeyMult, mult);
    write_reg(acbs_pkg::CfgKeyAdd, add);
    write_reg(acbs_pkg::CfgDirection, {4'($urandom_range(15)), dec});
  endtask

  // the four alphabet edges, last flag on the second and the final one
  task automatic send_edges();
    send_word(acbs_pkg::CharLowerA, 1'b0);
    send_word(acbs_pkg::CharLowerZ, 1'b1);
    send_word(acbs_pkg::CharUpperA, 1'b0);
    send_word(acbs_pkg::CharUpperZ, 1'b1);
  endtask

  // reset keys are the identity map: letters, their neighbors, zero and high bytes
  task automatic test_reset_defaults();
    send_edges();
    send_word(acbs_pkg::CharLowerA - 8'd1, 1'b0);
    send_word(acbs_pkg::CharLowerZ + 8'd1, 1'b1);
    send_word(acbs_pkg::CharUpperA - 8'd1, 1'b0);
    send_word(acbs_pkg::CharUpperZ + 8'd1, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b1);
  endtask

  // keys past 25, zero multiplier, non-invertible decrypt, ignored index
  task automatic test_special_keys();
    // 26 reduces to a zero multiplier: every letter lands on the offset
    set_keys(5'd26, 5'd0, 1'b0);
    send_edges();
    // 31 acts as 5 for both keys
    set_keys(5'd31, 5'd31, 1'b0);
    send_edges();
    // 13 has no inverse: error flag, letters untouched
    set_keys(5'd13, 5'd3, 1'b1);
    send_edges();
    // zero multiplier in decrypt mode is an error too
    set_keys(5'd26, 5'd25, 1'b1);
    send_edges();
    // write to the unused index must not disturb the keys
    set_keys(5'd25, 5'd25, 1'b1);
    write_reg(CfgNone, 5'h1f);
    send_edges();
  endtask

  // random keys per phase, extremes at both ends of the sweep
  task automatic test_random_keys();
    for (int unsigned p = 0; p < 10; p++) begin
      case (p)
        0:       set_keys(5'd1, 5'd0, 1'b1);
        1:       set_keys(5'd25, 5'd25, 1'b0);
        9:       set_keys(5'd31, 5'd31, 1'b1);
        default: set_keys(5'($urandom_range(31)), 5'($urandom_range(31)),
                          1'($urandom_range(1)));
      endcase
      if ($urandom_range(3) == 0) write_reg(CfgNone, 5'($urandom_range(31)));
      repeat (10) send_string($urandom_range(1, 12));
    end
  endtask

  // long stretch at full rate on both sides
  task automatic test_full_rate();
    set_keys(5'($urandom_range(31)), 5'($urandom_range(31)), 1'($urandom_range(1)));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (15) send_string($urandom_range(5, 15));
    wait_drained();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // receiver holds off while the sender keeps pushing, so the block fills up
  task automatic test_backpressure();
    set_keys(5'd7, 5'd11, 1'b1);
    hold_cycles = 300;
    send_idle = 1'b0;
    repeat (20) send_string(10);
    wait_drained();
    send_idle = 1'b1;
  endtask

  // receiver: random pop gaps, or a counted hold-off when one is requested
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= !recv_idle || ($urandom_range(99) >= 24);
      end
    end
  end

  // compare each word taken from the block with the oldest prediction
  always @(posedge clk_i) begin
    acbs_pkg::out_word_t exp_w;
    if (rst_ni && pop && !empty) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected word: out_char %0h out_last %0b key_error %0b",
               out_word_o.out_char, out_word_o.out_last, out_word_o.key_error);
        err_cnt++;
      end else begin
        exp_w = cipher_q.pop_front();
        if (out_word_o.out_char !== exp_w.out_char) begin
          $error("out_char: expected %0h actual %0h", exp_w.out_char, out_word_o.out_char);
          err_cnt++;
        end
        if (out_word_o.out_last !== exp_w.out_last) begin
          $error("out_last: expected %0b actual %0b", exp_w.out_last, out_word_o.out_last);
          err_cnt++;
        end
        if (out_word_o.key_error !== exp_w.key_error) begin
          $error("key_error: expected %0b actual %0b",
                 exp_w.key_error, out_word_o.key_error);
          err_cnt++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = acbs_pkg::CfgKeyMult;
    cfg_data_i  = '0;
    push        = 1'b0;
    in_word_i   = '0;
    err_cnt     = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    hold_cycles = 0;
    // reset values of the key registers
    key_mult_q  = 5'd1;
    key_add_q   = 5'd0;
    decrypt_q   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_special_keys();
    test_random_keys();
    test_full_rate();
    test_backpressure();

    // let any stray word show up before the verdict
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
